FILE: sv/update_frame_receiver_unit_macros.svh
// Assertion macros shared by the update frame receiver modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef UPDATE_FRAME_RECEIVER_UNIT_MACROS_SVH
`define UPDATE_FRAME_RECEIVER_UNIT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define UFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define UFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ufr_pkg.sv
// Package for the update frame receiver: event codes, phases, result types,
// header constants and the bytewise CRC-32 function. Depends on nothing.
package ufr_pkg;

    localparam int          OFFSET_W            = 24;
    localparam int          LENGTH_BITS         = 24;
    localparam logic [31:0] LEN_MASK            = 32'hFFFF_FFFF >> (32 - LENGTH_BITS);
    localparam logic [31:0] MAGIC_WORD          = 32'h3044_5055;
    localparam logic [31:0] CRC_POLY            = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT            = 32'hFFFF_FFFF;
    localparam logic [23:0] DEFAULT_MAX_LEN     = 24'd57344;
    localparam int          DEFAULT_CHUNK_BYTES = 256;
    localparam int          MAX_RESULTS         = 3;
    localparam int          QUEUE_DEPTH         = 4;

    typedef enum logic [2:0] {
        EV_HEADER  = 3'd0,
        EV_DROP    = 3'd1,
        EV_LEN_ERR = 3'd2,
        EV_HDR_OK  = 3'd3,
        EV_WRITE   = 3'd4,
        EV_ACK     = 3'd5,
        EV_CRC_ERR = 3'd6,
        EV_IMG_OK  = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        PH_MAGIC   = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        event_t                event_res;
        logic [OFFSET_W-1:0]   byte_offset;
        logic [7:0]            write_data;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   cnt;
        result_t [MAX_RESULTS-1:0]    res;
    } push_t;

    // Reflected CRC-32 update over one byte, register kept non-inverted.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

FILE: sv/ufr_frame_core.sv
// Frame state and per-byte decode for the update frame receiver.
// Depends on ufr_pkg; produces up to three results for each processed byte.
module ufr_frame_core #(
    parameter int CHUNK_BYTES = ufr_pkg::DEFAULT_CHUNK_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [23:0]          max_image_length,
    input  logic                 fire,
    input  logic [7:0]           byte_in,
    output ufr_pkg::push_t       push
);

    localparam int                ChunkW    = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam logic [ChunkW-1:0] ChunkLast = ChunkW'(CHUNK_BYTES - 1);
    localparam logic [ChunkW-1:0] ChunkOne  = ChunkW'(1);

    ufr_pkg::phase_t                    phase_reg, phase_next;
    logic [3:0]                         header_count_reg, header_count_next;
    logic [31:0]                        header_shift_reg, header_shift_next;
    logic [ufr_pkg::OFFSET_W-1:0]       image_length_reg, image_length_next;
    logic [ufr_pkg::OFFSET_W-1:0]       payload_offset_reg, payload_offset_next;
    logic [31:0]                        running_crc_reg, running_crc_next;
    logic [31:0]                        expected_crc_reg, expected_crc_next;
    logic [ChunkW-1:0]                  chunk_cnt_reg, chunk_cnt_next;

    logic [3:0]                         count_inc;
    logic [ufr_pkg::OFFSET_W-1:0]       offset_inc;
    logic                               done;
    logic                               chunk_end;
    logic [31:0]                        crc_new;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg          <= ufr_pkg::PH_MAGIC;
            header_count_reg   <= '0;
            header_shift_reg   <= '0;
            image_length_reg   <= '0;
            payload_offset_reg <= '0;
            running_crc_reg    <= ufr_pkg::CRC_INIT;
            expected_crc_reg   <= '0;
            chunk_cnt_reg      <= '0;
        end else if (fire) begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            header_shift_reg   <= header_shift_next;
            image_length_reg   <= image_length_next;
            payload_offset_reg <= payload_offset_next;
            running_crc_reg    <= running_crc_next;
            expected_crc_reg   <= expected_crc_next;
            chunk_cnt_reg      <= chunk_cnt_next;
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        header_shift_next   = header_shift_reg;
        image_length_next   = image_length_reg;
        payload_offset_next = payload_offset_reg;
        running_crc_next    = running_crc_reg;
        expected_crc_next   = expected_crc_reg;
        chunk_cnt_next      = chunk_cnt_reg;

        count_inc  = header_count_reg + 4'd1;
        offset_inc = payload_offset_reg + 24'd1;
        done       = (offset_inc == image_length_reg);
        chunk_end  = (chunk_cnt_reg == ChunkLast) || done;
        crc_new    = ufr_pkg::crc_byte(running_crc_reg, byte_in);

        push.cnt = 2'd1;
        for (int k = 0; k < ufr_pkg::MAX_RESULTS; k++) begin
            push.res[k]           = '0;
            push.res[k].event_res = ufr_pkg::EV_HEADER;
            push.res[k].last      = 1'b1;
        end

        unique case (phase_reg)
            ufr_pkg::PH_HEADER: begin
                if (header_count_reg < 4'd4) begin
                    header_shift_next = {byte_in, header_shift_reg[31:8]};
                end else begin
                    expected_crc_next = {byte_in, expected_crc_reg[31:8]};
                end
                if (count_inc < 4'd8) begin
                    header_count_next = count_inc;
                end else begin
                    header_count_next = '0;
                    if ((header_shift_next == 32'd0) || (header_shift_next > ufr_pkg::LEN_MASK)
                        || (header_shift_next > {8'd0, max_image_length})) begin
                        phase_next            = ufr_pkg::PH_MAGIC;
                        header_shift_next     = '0;
                        push.res[0].event_res = ufr_pkg::EV_LEN_ERR;
                    end else begin
                        image_length_next     = header_shift_next[ufr_pkg::OFFSET_W-1:0];
                        payload_offset_next   = '0;
                        running_crc_next      = ufr_pkg::CRC_INIT;
                        chunk_cnt_next        = '0;
                        phase_next            = ufr_pkg::PH_PAYLOAD;
                        push.res[0].event_res = ufr_pkg::EV_HDR_OK;
                    end
                end
            end
            ufr_pkg::PH_PAYLOAD: begin
                running_crc_next        = crc_new;
                payload_offset_next     = offset_inc;
                chunk_cnt_next          = chunk_end ? '0 : chunk_cnt_reg + ChunkOne;
                push.res[0].event_res   = ufr_pkg::EV_WRITE;
                push.res[0].byte_offset = payload_offset_reg;
                push.res[0].write_data  = byte_in;
                push.res[0].last        = !chunk_end;
                if (chunk_end) begin
                    push.cnt              = 2'd2;
                    push.res[1].event_res = ufr_pkg::EV_ACK;
                    push.res[1].last      = !done;
                end
                if (done) begin
                    push.cnt              = 2'd3;
                    push.res[2].event_res = ((~crc_new) == expected_crc_reg)
                                            ? ufr_pkg::EV_IMG_OK : ufr_pkg::EV_CRC_ERR;
                    phase_next            = ufr_pkg::PH_MAGIC;
                    header_count_next     = '0;
                    header_shift_next     = '0;
                end
            end
            default: begin
                // waiting for magic; the unused phase code lands here too
                phase_next        = ufr_pkg::PH_MAGIC;
                header_shift_next = {byte_in, header_shift_reg[31:8]};
                if (count_inc < 4'd4) begin
                    header_count_next = count_inc;
                end else begin
                    header_count_next = '0;
                    if (header_shift_next == ufr_pkg::MAGIC_WORD) begin
                        phase_next = ufr_pkg::PH_HEADER;
                    end else begin
                        push.res[0].event_res = ufr_pkg::EV_DROP;
                    end
                    header_shift_next = '0;
                end
            end
        endcase
    end

endmodule

FILE: sv/ufr_result_queue.sv
// Four-entry result queue for the update frame receiver: takes up to three
// results per cycle, releases one. Depends on ufr_pkg and the macro header.
`include "update_frame_receiver_unit_macros.svh"

module ufr_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ufr_pkg::push_t     push,
    input  logic               pop,
    output ufr_pkg::result_t   head,
    output logic               not_empty,
    output logic               space_ok
);

    localparam int PtrW = $clog2(ufr_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(ufr_pkg::QUEUE_DEPTH + 1);

    ufr_pkg::result_t   entries_reg [ufr_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CntW'(push.cnt) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < ufr_pkg::MAX_RESULTS; k++) begin
            if (k < int'(push.cnt)) begin
                entries_reg[wr_ptr_reg + PtrW'(k)] <= push.res[k];
            end
        end
    end

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // room for a full burst, counting the slot freed this cycle
    assign space_ok  = (count_reg - CntW'(pop))
                       <= CntW'(ufr_pkg::QUEUE_DEPTH - ufr_pkg::MAX_RESULTS);

    `UFR_ASSERT_ALWAYS(a_count_bound, count_reg <= CntW'(ufr_pkg::QUEUE_DEPTH), "queue overflow")
    `UFR_ASSERT_NEXT(a_count_track, (push.cnt != 2'd0) && !pop, count_reg == $past(count_reg) + CntW'($past(push.cnt)), "queue count lost a push")
    `UFR_ASSERT_ALWAYS(a_ptr_gap, wr_ptr_reg == rd_ptr_reg + PtrW'(count_reg), "queue pointers disagree with count")

endmodule

FILE: sv/update_frame_receiver_unit.sv
// Top level of the update frame receiver: input register, frame core and
// result queue. Depends on ufr_pkg, ufr_frame_core, ufr_result_queue, macros.
//
// Use: received image bytes enter on in_valid/in_ready/data_byte, one byte
// per transaction. Each byte yields one to three result transactions on
// out_valid/out_ready (event_res, byte_offset, write_data, last): a plain
// header or payload byte gives one, the last byte of a chunk gives a write
// and an ack, the last payload byte adds the crc error or image ok report.
// last marks the final result of a byte.
// A byte taken is held in the input register, then decoded and pushed
// into the result queue once the queue can absorb a full burst; the queue
// head drives the outputs.
// Throughput: one byte per cycle while each byte gives one result and
// out_ready is high; a byte with two or three results needs as many output
// transactions through the single-result port draining the four-entry queue.
// The limit register max_image_length is written on cfg_valid/cfg_ready,
// always ready; write it only while the block is idle.
// Reset clears the frame state (waiting for magic, CRC all ones), empties
// the queue and loads the default limit. When the receiver stalls, results
// hold in the queue; once it cannot take a full burst the input register
// holds its byte and in_ready drops.
`include "update_frame_receiver_unit_macros.svh"

module update_frame_receiver_unit #(
    parameter int CHUNK_BYTES = ufr_pkg::DEFAULT_CHUNK_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [23:0] byte_offset,
    output logic [7:0]  write_data,
    output logic        last
);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic [23:0]        max_len_reg;
    logic               fire;
    logic               space_ok;
    logic               pop;
    ufr_pkg::push_t     core_push;
    ufr_pkg::push_t     queue_push;
    ufr_pkg::result_t   head;

    // Configuration: always take the write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_len_reg <= ufr_pkg::DEFAULT_MAX_LEN;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    // Decode the held byte once the queue can absorb a full burst.
    assign fire     = in_vld_reg && space_ok;
    assign in_ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= data_byte;
        end
    end

    ufr_frame_core #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_image_length (max_len_reg),
        .fire             (fire),
        .byte_in          (in_byte_reg),
        .push             (core_push)
    );

    // Push nothing on cycles without a decoded byte.
    always_comb begin
        queue_push     = core_push;
        queue_push.cnt = fire ? core_push.cnt : 2'd0;
    end

    assign pop = out_valid && out_ready;

    ufr_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .space_ok  (space_ok)
    );

    assign event_res   = head.event_res;
    assign byte_offset = head.byte_offset;
    assign write_data  = head.write_data;
    assign last        = head.last;

    `UFR_ASSERT_NEXT(a_in_held, in_valid && in_ready, in_vld_reg, "accepted byte not held")
    `UFR_ASSERT_ALWAYS(a_fire_results, !fire || (core_push.cnt != 2'd0), "decoded byte gave no result")
    `UFR_ASSERT_NEXT(a_stall_holds, in_vld_reg && !space_ok, in_vld_reg && $stable(in_byte_reg), "held byte lost during stall")

endmodule
